### rtl/aerator_risk_hysteresis_control_macros.svh
// Assertion macros for the aerator controller.
`ifndef AERATOR_RISK_HYSTERESIS_CONTROL_MACROS_SVH
`define AERATOR_RISK_HYSTERESIS_CONTROL_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ARHC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define ARHC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/arhc_pkg.sv
// Shared constants for the aerator risk and hysteresis controller.
package arhc_pkg;

	localparam int DO_W   = 16;
	localparam int TIME_W = 32;
	localparam int MOD_W  = 11;
	localparam int SCORE_W = 13;
	localparam int REASON_W = 3;
	localparam int CFG_W  = 40;
	localparam int CFG_AW = 3;

	// Decision reason codes
	localparam logic [REASON_W-1:0] RSN_NORMAL  = 3'd0;
	localparam logic [REASON_W-1:0] RSN_DO_LOW  = 3'd1;
	localparam logic [REASON_W-1:0] RSN_SCORE   = 3'd2;
	localparam logic [REASON_W-1:0] RSN_COMBINED = 3'd3;
	localparam logic [REASON_W-1:0] RSN_HOLD    = 3'd4;
	localparam logic [REASON_W-1:0] RSN_FAILSAFE = 3'd5;
	localparam logic [REASON_W-1:0] RSN_BAT_LOW = 3'd6;

	// Configuration register indexes
	localparam logic [CFG_AW-1:0] REG_DO_ON    = 3'd0;
	localparam logic [CFG_AW-1:0] REG_DO_OFF   = 3'd1;
	localparam logic [CFG_AW-1:0] REG_NH3      = 3'd2;
	localparam logic [CFG_AW-1:0] REG_BAT_LOW  = 3'd3;
	localparam logic [CFG_AW-1:0] REG_HIGH     = 3'd4;
	localparam logic [CFG_AW-1:0] REG_LOW      = 3'd5;
	localparam logic [CFG_AW-1:0] REG_WEIGHTS  = 3'd6;
	localparam logic [CFG_AW-1:0] REG_FAILSAFE = 3'd7;

	// Risk term indexes, also the weight byte number
	localparam logic [2:0] RK_DO   = 3'd0;
	localparam logic [2:0] RK_TREND = 3'd1;
	localparam logic [2:0] RK_NH3  = 3'd2;
	localparam logic [2:0] RK_TEMP = 3'd3;
	localparam logic [2:0] RK_TIME = 3'd4;

	localparam logic [10:0] Q_ONE = 11'd1024;
	localparam logic [10:0] Q_QUARTER = 11'd256;

endpackage

### rtl/arhc_if.sv
// Valid/ready channel interfaces for samples and results.
interface arhc_sample_if;
	logic               valid;
	logic               ready;
	logic [15:0]        do_level;
	logic [31:0]        do_time_ms;
	logic [15:0]        nh3_level;
	logic signed [15:0] temperature;
	logic [15:0]        battery_mv;
	logic               battery_valid;
	logic [10:0]        minute_of_day;
	logic               sensors_valid;

	modport source (output valid, do_level, do_time_ms, nh3_level, temperature,
		battery_mv, battery_valid, minute_of_day, sensors_valid, input ready);
	modport sink (input valid, do_level, do_time_ms, nh3_level, temperature,
		battery_mv, battery_valid, minute_of_day, sensors_valid, output ready);
endinterface

interface arhc_result_if;
	logic               valid;
	logic               ready;
	logic               aerator_on;
	logic [2:0]         decision_reason;
	logic [12:0]        risk_score;
	logic signed [15:0] do_trend;

	modport source (output valid, aerator_on, decision_reason, risk_score, do_trend,
		input ready);
	modport sink (input valid, aerator_on, decision_reason, risk_score, do_trend,
		output ready);
endinterface

### rtl/aerator_risk_hysteresis_control.sv
// Aerator controller: oxygen trend, weighted risk score and hysteresis switching.
// A valid sample runs the trend divide (previous sample, positive dt), then each of four
//   risk terms, with a divide when a quotient is needed, then the time term, the scaling
//   and the result load; an invalid sample runs only the trend divide, if any.
// The block takes one sample at a time; the next transfer can come in the cycle after the result loads.
// Reset clears the aerator state, previous sample and control; registers take defaults.
module aerator_risk_hysteresis_control #(
	parameter int TREND_SCALE = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [arhc_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [arhc_pkg::CFG_W-1:0]   cfg_wdata,
	arhc_sample_if.sink                  sample,
	arhc_result_if.source                result
);
	import arhc_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_TDIV  = 6'b000010,
		S_RISK  = 6'b000100,
		S_RDIV  = 6'b001000,
		S_SCALE = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [15:0] cfg_on_q, cfg_off_q, cfg_nh3_q, cfg_bat_q;
	logic [12:0] cfg_high_q, cfg_low_q;
	logic [39:0] cfg_wts_q;
	logic        cfg_fs_q;

	// Controller state
	logic        aer_q;
	logic [15:0] last_do_q;
	logic [31:0] last_time_q;
	logic        have_last_q;

	// Captured sample
	logic [15:0]        dol_q, nh3_q, bat_q;
	logic signed [15:0] temp_q;
	logic               batv_q, sval_q, neg_q;
	logic [10:0]        mod_q;

	// Work registers
	logic signed [15:0] trend_q;
	logic [2:0]  k_q;
	logic [20:0] acc_q;
	logic [30:0] prod_q;
	logic [31:0] rem_q, quo_q, dvs_q;
	logic [4:0]  cnt_q;

	// Output register
	logic        ovalid_q, oaer_q;
	logic [2:0]  orsn_q;
	logic [12:0] oscore_q;
	logic signed [15:0] otrend_q;

	// Accept-time trend setup
	logic        in_xfer;
	logic [31:0] dt;
	logic        trend_go, dneg;
	logic [15:0] mag;

	assign sample.ready = (state_q == S_IDLE);
	assign in_xfer = sample.valid && sample.ready;
	assign dt = sample.do_time_ms - last_time_q;
	assign dneg = sample.do_level < last_do_q;
	assign mag = dneg ? (last_do_q - sample.do_level) : (sample.do_level - last_do_q);
	assign trend_go = have_last_q && (dt != 32'd0) && !dt[31];

	// Restoring divider step: one quotient bit per cycle
	logic [32:0] dtry;
	logic        dge;
	logic [31:0] drem_n, dquo_n;
	assign dtry = {rem_q, quo_q[31]};
	assign dge = dtry >= {1'b0, dvs_q};
	assign drem_n = dge ? 32'(dtry - {1'b0, dvs_q}) : dtry[31:0];
	assign dquo_n = {quo_q[30:0], dge};
	logic div_last;
	assign div_last = (cnt_q == 5'd31);

	// Saturate the trend quotient
	logic signed [15:0] trend_sat;
	always_comb begin
		if (neg_q) begin
			trend_sat = (dquo_n > 32'd32768) ? 16'sh8000 : 16'(-dquo_n);
		end else begin
			trend_sat = (dquo_n > 32'd32767) ? 16'sd32767 : 16'(dquo_n);
		end
	end

	// Select the numerator and divisor of the current risk term
	logic signed [17:0] rnum;
	logic [16:0]        rden;
	always_comb begin
		case (k_q)
			RK_DO: begin
				rnum = $signed({2'b00, cfg_off_q}) - $signed({2'b00, dol_q});
				rden = 17'd200;
			end
			RK_TREND: begin
				rnum = -18'(trend_q);
				rden = 17'(TREND_SCALE);
			end
			RK_NH3: begin
				rnum = $signed({2'b00, nh3_q});
				rden = {1'b0, cfg_nh3_q};
			end
			RK_TEMP: begin
				rnum = 18'(temp_q) - 18'sd3000;
				rden = 17'd500;
			end
			default: begin
				rnum = '0;
				rden = 17'd1;
			end
		endcase
	end

	logic r_zero, r_one, night;
	assign r_zero = (rnum <= 18'sd0) && (rden != 17'd0);
	assign r_one = (rden == 17'd0) || (rnum >= $signed({1'b0, rden}));
	assign night = (mod_q >= 11'd1080) || (mod_q < 11'd360);

	// Risk value for the accumulator and its weight
	logic [10:0] risk_v;
	logic        mac_en;
	logic [7:0]  wgt;
	assign wgt = cfg_wts_q[{k_q, 3'b000} +: 8];
	always_comb begin
		risk_v = '0;
		mac_en = 1'b0;
		if (state_q == S_RISK) begin
			if (k_q == RK_TIME) begin
				risk_v = night ? Q_ONE : Q_QUARTER;
				mac_en = 1'b1;
			end else if (r_one) begin
				risk_v = Q_ONE;
				mac_en = 1'b1;
			end else if (r_zero) begin
				mac_en = 1'b1;
			end
		end else if (state_q == S_RDIV && div_last) begin
			risk_v = dquo_n[10:0];
			mac_en = 1'b1;
		end
	end

	// Final decision
	logic [12:0] score;
	logic        aer_n;
	logic [2:0]  rsn_n;
	logic        bat_low;
	assign score = prod_q[30:18];
	assign bat_low = batv_q && (bat_q < cfg_bat_q);
	always_comb begin
		aer_n = aer_q;
		rsn_n = bat_low ? RSN_BAT_LOW : RSN_HOLD;
		if (!sval_q) begin
			aer_n = cfg_fs_q;
			rsn_n = RSN_FAILSAFE;
		end else if (dol_q < cfg_on_q) begin
			aer_n = 1'b1;
			rsn_n = RSN_DO_LOW;
		end else if (nh3_q >= cfg_nh3_q && score >= cfg_high_q) begin
			aer_n = 1'b1;
			rsn_n = RSN_COMBINED;
		end else if (score >= cfg_high_q) begin
			aer_n = 1'b1;
			rsn_n = RSN_SCORE;
		end else if (dol_q > cfg_off_q && score < cfg_low_q) begin
			aer_n = 1'b0;
			rsn_n = bat_low ? RSN_BAT_LOW : RSN_NORMAL;
		end
	end

	logic out_load;
	assign out_load = (state_q == S_DONE) && (!ovalid_q || result.ready);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_on_q   <= 16'd400;
			cfg_off_q  <= 16'd600;
			cfg_nh3_q  <= 16'd50;
			cfg_bat_q  <= 16'd11500;
			cfg_high_q <= 13'd700;
			cfg_low_q  <= 13'd400;
			cfg_wts_q  <= 40'h331A33334D;
			cfg_fs_q   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_DO_ON:    cfg_on_q   <= cfg_wdata[15:0];
				REG_DO_OFF:   cfg_off_q  <= cfg_wdata[15:0];
				REG_NH3:      cfg_nh3_q  <= cfg_wdata[15:0];
				REG_BAT_LOW:  cfg_bat_q  <= cfg_wdata[15:0];
				REG_HIGH:     cfg_high_q <= cfg_wdata[12:0];
				REG_LOW:      cfg_low_q  <= cfg_wdata[12:0];
				REG_WEIGHTS:  cfg_wts_q  <= cfg_wdata;
				REG_FAILSAFE: cfg_fs_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			aer_q       <= 1'b0;
			last_do_q   <= '0;
			last_time_q <= '0;
			have_last_q <= 1'b0;
			ovalid_q    <= 1'b0;
			cnt_q       <= '0;
			k_q         <= '0;
		end else begin
			// Raise valid when a result loads, drop it after its transfer
			if (out_load) ovalid_q <= 1'b1;
			else if (result.valid && result.ready) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						last_do_q   <= sample.do_level;
						last_time_q <= sample.do_time_ms;
						have_last_q <= 1'b1;
						cnt_q       <= '0;
						k_q         <= RK_DO;
						if (trend_go) state_q <= S_TDIV;
						else if (sample.sensors_valid) state_q <= S_RISK;
						else state_q <= S_DONE;
					end
				end
				S_TDIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (div_last) state_q <= sval_q ? S_RISK : S_DONE;
				end
				S_RISK: begin
					cnt_q <= '0;
					if (k_q == RK_TIME) state_q <= S_SCALE;
					else if (mac_en) k_q <= k_q + 3'd1;
					else state_q <= S_RDIV;
				end
				S_RDIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (div_last) begin
						k_q     <= k_q + 3'd1;
						state_q <= S_RISK;
					end
				end
				S_SCALE: state_q <= S_DONE;
				S_DONE: begin
					if (out_load) begin
						aer_q    <= aer_n;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			dol_q   <= sample.do_level;
			nh3_q   <= sample.nh3_level;
			temp_q  <= sample.temperature;
			bat_q   <= sample.battery_mv;
			batv_q  <= sample.battery_valid;
			mod_q   <= sample.minute_of_day;
			sval_q  <= sample.sensors_valid;
			neg_q   <= dneg;
			acc_q   <= '0;
			trend_q <= '0;
			rem_q   <= '0;
			quo_q   <= 32'(mag * 32'd60000);
			dvs_q   <= dt;
		end
		if (state_q == S_TDIV || state_q == S_RDIV) begin
			rem_q <= drem_n;
			quo_q <= dquo_n;
		end
		if (state_q == S_TDIV && div_last) trend_q <= trend_sat;
		// Load the divider for a fractional risk
		if (state_q == S_RISK && !mac_en) begin
			rem_q <= '0;
			quo_q <= {6'b0, rnum[15:0], 10'b0};
			dvs_q <= {15'b0, rden};
		end
		if (mac_en) acc_q <= acc_q + 21'(wgt) * 21'(risk_v);
		if (state_q == S_SCALE) prod_q <= 31'(acc_q) * 31'(1000);
		if (out_load) begin
			oaer_q   <= aer_n;
			orsn_q   <= rsn_n;
			oscore_q <= sval_q ? score : 13'd0;
			otrend_q <= trend_q;
		end
	end

	assign result.valid           = ovalid_q;
	assign result.aerator_on      = oaer_q;
	assign result.decision_reason = orsn_q;
	assign result.risk_score      = oscore_q;
	assign result.do_trend        = otrend_q;

	`include "aerator_risk_hysteresis_control_macros.svh"

	`ARHC_ASSERT_NEXT(a_busy_after_accept, in_xfer, !sample.ready, "accepted while busy")
	`ARHC_ASSERT_NOW(a_failsafe_zero, result.valid && result.decision_reason == RSN_FAILSAFE,
		result.risk_score == 13'd0, "fail-safe result with nonzero score")
	`ARHC_ASSERT_NOW(a_on_reasons, result.valid && (result.decision_reason == RSN_DO_LOW ||
		result.decision_reason == RSN_SCORE || result.decision_reason == RSN_COMBINED),
		result.aerator_on, "switch-on reason with aerator off")
	`ARHC_ASSERT_NOW(a_score_range, result.valid, result.risk_score <= 13'd5000,
		"score out of range")

endmodule

### tb/sv/aerator_risk_hysteresis_control_tb.sv
// Self-checking testbench for the aerator risk and hysteresis controller.
module aerator_risk_hysteresis_control_tb;
	import arhc_pkg::*;

	localparam int TREND_DIV = 10;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct packed {
		logic [15:0]        do_level;
		logic [31:0]        do_time_ms;
		logic [15:0]        nh3_level;
		logic signed [15:0] temperature;
		logic [15:0]        battery_mv;
		logic               battery_valid;
		logic [10:0]        minute_of_day;
		logic               sensors_valid;
	} sample_t;

	typedef struct packed {
		logic               aerator_on;
		logic [2:0]         decision_reason;
		logic [12:0]        risk_score;
		logic signed [15:0] do_trend;
	} decision_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_AW-1:0] cfg_addr;
	logic [CFG_W-1:0] cfg_wdata;

	arhc_sample_if sample_ch ();
	arhc_result_if result_ch ();

	aerator_risk_hysteresis_control dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata), .sample(sample_ch.sink), .result(result_ch.source)
	);

	// Predictor copy of registers and state
	logic [15:0] p_do_on, p_do_off, p_nh3_alarm, p_bat_low;
	logic [12:0] p_high, p_low;
	logic [39:0] p_weights;
	logic        p_fail_safe;
	logic        p_aerator;
	logic [15:0] p_last_do;
	logic [31:0] p_last_time;
	logic        p_have_last;

	decision_t expected_decisions[$];
	int mismatches;
	int idle_cycles;
	bit hold_off;
	logic [31:0] clock_ms;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned clamp_risk(longint num, longint den);
		longint q;
		if (num <= 0 || den <= 0) return 0;
		if (num >= den) return 1024;
		q = (num * 1024) / den;
		return (q > 1024) ? 1024 : int'(q);
	endfunction

	// Work out one decision and advance the predictor state
	function automatic decision_t decide_sample(sample_t s);
		decision_t d;
		logic [31:0] dt;
		longint mag, q, acc, score;
		int trend;
		int unsigned rk[5];
		logic [2:0] why;
		trend = 0;
		if (p_have_last) begin
			dt = s.do_time_ms - p_last_time;
			if (dt != 0 && dt < 32'h8000_0000) begin
				if (s.do_level < p_last_do) begin
					mag = longint'(p_last_do - s.do_level);
					q = (mag * 60000) / longint'(dt);
					trend = (q > 32768) ? -32768 : -int'(q);
				end else begin
					mag = longint'(s.do_level - p_last_do);
					q = (mag * 60000) / longint'(dt);
					trend = (q > 32767) ? 32767 : int'(q);
				end
			end
		end
		p_last_do = s.do_level;
		p_last_time = s.do_time_ms;
		p_have_last = 1'b1;
		d.do_trend = trend[15:0];
		if (!s.sensors_valid) begin
			p_aerator = p_fail_safe;
			d.aerator_on = p_aerator;
			d.decision_reason = RSN_FAILSAFE;
			d.risk_score = '0;
			return d;
		end
		rk[0] = clamp_risk(longint'(p_do_off) - longint'(s.do_level), longint'(200));
		rk[1] = clamp_risk(-longint'(trend), longint'(TREND_DIV));
		rk[2] = (p_nh3_alarm == 0) ? 1024
			: clamp_risk(longint'(s.nh3_level), longint'(p_nh3_alarm));
		rk[3] = clamp_risk(longint'(s.temperature) - 3000, longint'(500));
		rk[4] = (s.minute_of_day >= 1080 || s.minute_of_day < 360) ? 1024 : 256;
		acc = 0;
		for (int k = 0; k < 5; k++)
			acc += longint'(p_weights[8*k +: 8]) * longint'(rk[k]);
		score = (acc * 1000) / 262144;
		why = RSN_NORMAL;
		if (s.battery_valid && s.battery_mv < p_bat_low) why = RSN_BAT_LOW;
		if (s.do_level < p_do_on) begin
			p_aerator = 1'b1;
			why = RSN_DO_LOW;
		end else if (s.nh3_level >= p_nh3_alarm && score >= longint'(p_high)) begin
			p_aerator = 1'b1;
			why = RSN_COMBINED;
		end else if (score >= longint'(p_high)) begin
			p_aerator = 1'b1;
			why = RSN_SCORE;
		end else if (s.do_level > p_do_off && score < longint'(p_low)) begin
			p_aerator = 1'b0;
			if (why != RSN_BAT_LOW) why = RSN_NORMAL;
		end else if (why != RSN_BAT_LOW) begin
			why = RSN_HOLD;
		end
		d.aerator_on = p_aerator;
		d.decision_reason = why;
		d.risk_score = score[12:0];
		return d;
	endfunction

	// Write one register while the block is idle
	task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DO_ON:    p_do_on = val[15:0];
			REG_DO_OFF:   p_do_off = val[15:0];
			REG_NH3:      p_nh3_alarm = val[15:0];
			REG_BAT_LOW:  p_bat_low = val[15:0];
			REG_HIGH:     p_high = val[12:0];
			REG_LOW:      p_low = val[12:0];
			REG_WEIGHTS:  p_weights = val[39:0];
			REG_FAILSAFE: p_fail_safe = val[0];
			default: ;
		endcase
	endtask

	// Offer one sample after a random gap, record its decision on transfer
	task automatic send_sample(sample_t s);
		int gap;
		gap = $urandom_range(0, 3);
		// Drop valid only across a gap, so back-to-back offers keep it high
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.do_level <= s.do_level;
		sample_ch.do_time_ms <= s.do_time_ms;
		sample_ch.nh3_level <= s.nh3_level;
		sample_ch.temperature <= s.temperature;
		sample_ch.battery_mv <= s.battery_mv;
		sample_ch.battery_valid <= s.battery_valid;
		sample_ch.minute_of_day <= s.minute_of_day;
		sample_ch.sensors_valid <= s.sensors_valid;
		do @(posedge clk); while (!sample_ch.ready);
		expected_decisions.push_back(decide_sample(s));
	endtask

	// Wait until every decision has come, then let the block settle
	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (expected_decisions.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic sample_t random_sample();
		sample_t s;
		logic [127:0] raw;
		int pick;
		raw = {$urandom, $urandom, $urandom, $urandom};
		s = raw[108:0];
		pick = $urandom_range(0, 9);
		// Mostly steady clock with realistic deltas, sometimes wild stamps
		if (pick < 7) begin
			clock_ms = clock_ms + $urandom_range(1, 120000);
			s.do_time_ms = clock_ms;
			s.do_level = 16'($urandom_range(0, 1200));
			s.nh3_level = 16'($urandom_range(0, 150));
			s.temperature = 16'($urandom_range(2000, 4000));
		end else if (pick == 7) begin
			s.do_time_ms = clock_ms;
		end
		s.sensors_valid = ($urandom_range(0, 9) != 0);
		if ($urandom_range(0, 3) == 0) s.minute_of_day = 11'($urandom_range(0, 2047));
		else s.minute_of_day = 11'($urandom_range(0, 1439));
		return s;
	endfunction

	task automatic run_random(int count);
		repeat (count) send_sample(random_sample());
	endtask

	// Field extremes, special cases and all reasons but score and combined
	task automatic test_directed();
		sample_t s;
		s = '{16'd800, 32'd1000, 16'd0, 16'sd2000, 16'd12000, 1'b1, 11'd600, 1'b1};
		send_sample(s);
		s.do_level = 16'd100; s.do_time_ms = 32'd61000;
		send_sample(s);
		s.do_time_ms = 32'd61000;
		send_sample(s);
		s.do_time_ms = 32'd1000;
		send_sample(s);
		s = '{16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'sh7FFF, 16'hFFFF, 1'b1, 11'h7FF, 1'b1};
		send_sample(s);
		s = '{16'd0, 32'd0, 16'd0, 16'sh8000, 16'd0, 1'b1, 11'd0, 1'b1};
		send_sample(s);
		s = '{16'd700, 32'd5000, 16'd60, 16'sd3600, 16'd100, 1'b1, 11'd1439, 1'b1};
		send_sample(s);
		s = '{16'd700, 32'd9000, 16'd10, 16'sd3600, 16'd100, 1'b1, 11'd1440, 1'b1};
		send_sample(s);
		s = '{16'd500, 32'd20000, 16'd10, 16'sd2500, 16'd100, 1'b1, 11'd700, 1'b1};
		send_sample(s);
		s = '{16'd500, 32'd30000, 16'd10, 16'sd2500, 16'd100, 1'b0, 11'd359, 1'b1};
		send_sample(s);
		s = '{16'd900, 32'd40000, 16'd0, 16'sd2000, 16'd100, 1'b1, 11'd1079, 1'b1};
		send_sample(s);
		s = '{16'd900, 32'd50000, 16'd0, 16'sd2000, 16'd13000, 1'b1, 11'd1080, 1'b1};
		send_sample(s);
		s = '{16'd100, 32'd60000, 16'd300, 16'sd3000, 16'd100, 1'b1, 11'd360, 1'b0};
		send_sample(s);
		drain();
	endtask

	// Sweep settings including extremes; fail-safe off, zero divisor
	task automatic test_config_sweep();
		write_reg(REG_FAILSAFE, 40'd0);
		write_reg(REG_NH3, 40'd0);
		write_reg(REG_WEIGHTS, 40'hFF_FFFF_FFFF);
		write_reg(REG_HIGH, 40'd5000);
		write_reg(REG_LOW, 40'd0);
		run_random(150);
		drain();
		write_reg(REG_DO_ON, 40'd0);
		write_reg(REG_DO_OFF, 40'd65535);
		write_reg(REG_NH3, 40'd65535);
		write_reg(REG_BAT_LOW, 40'd65535);
		write_reg(REG_HIGH, 40'd0);
		write_reg(REG_LOW, 40'd5000);
		write_reg(REG_WEIGHTS, 40'd0);
		run_random(150);
		drain();
		write_reg(REG_DO_ON, 40'd65535);
		write_reg(REG_DO_OFF, 40'd0);
		write_reg(REG_NH3, 40'd1);
		write_reg(REG_BAT_LOW, 40'd0);
		write_reg(REG_WEIGHTS, {8'($urandom), $urandom});
		write_reg(REG_FAILSAFE, 40'd1);
		run_random(150);
		drain();
		write_reg(REG_DO_ON, 40'd400);
		write_reg(REG_DO_OFF, 40'd600);
		write_reg(REG_NH3, 40'd50);
		write_reg(REG_BAT_LOW, 40'd11500);
		write_reg(REG_HIGH, 40'd700);
		write_reg(REG_LOW, 40'd400);
		write_reg(REG_WEIGHTS, 40'd219482895181);
	endtask

	// Block the result side long enough to back up the input
	task automatic test_back_pressure();
		hold_off = 1'b1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			run_random(12);
		join
		drain();
	endtask

	// Random traffic at default settings
	task automatic test_random_traffic();
		run_random(700);
		drain();
	endtask

	// Receiver: random stalls, compare each transfer with the oldest decision
	initial begin
		decision_t got, want;
		int stall;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
			// Drop ready only when this transfer waits
			if (stall > 0 || hold_off) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
				while (hold_off) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			got = '{result_ch.aerator_on, result_ch.decision_reason,
				result_ch.risk_score, result_ch.do_trend};
			if (expected_decisions.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected decision %p", got);
			end else begin
				want = expected_decisions.pop_front();
				if (got.aerator_on !== want.aerator_on
						|| got.decision_reason !== want.decision_reason
						|| got.risk_score !== want.risk_score
						|| got.do_trend !== want.do_trend) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.do_level = '0;
		sample_ch.do_time_ms = '0;
		sample_ch.nh3_level = '0;
		sample_ch.temperature = '0;
		sample_ch.battery_mv = '0;
		sample_ch.battery_valid = 1'b0;
		sample_ch.minute_of_day = '0;
		sample_ch.sensors_valid = 1'b0;
		hold_off = 1'b0;
		clock_ms = 32'd100000;
		p_do_on = 16'd400; p_do_off = 16'd600; p_nh3_alarm = 16'd50;
		p_bat_low = 16'd11500; p_high = 13'd700; p_low = 13'd400;
		p_weights = 40'd219482895181; p_fail_safe = 1'b1;
		p_aerator = 1'b0; p_last_do = '0; p_last_time = '0; p_have_last = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_config_sweep();
		test_back_pressure();
		test_random_traffic();
		if (mismatches == 0 && expected_decisions.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

### aerator_risk_hysteresis_control.f
+incdir+rtl
rtl/arhc_pkg.sv
rtl/arhc_if.sv
rtl/aerator_risk_hysteresis_control.sv
tb/sv/aerator_risk_hysteresis_control_tb.sv
